// ===== hw/rtl/mhtb_pkg.sv =====
// shared types and constants of the multicast hash table builder
// depends on nothing
`default_nettype none

package mhtb_pkg;

   localparam int HASH_LIMIT = 256;
   localparam int COUNT_W    = 9;
   localparam int WORD_COUNT = 8;
   localparam int WSEL_W     = 3;
   localparam int BSEL_W     = 5;
   localparam int MAC_W      = 48;
   localparam int BIT_CNT_W  = 6;

   localparam logic [31:0] CRC_POLY   = 32'h04C1_1DB7;
   localparam logic [31:0] CRC_PRESET = 32'hFFFF_FFFF;
   localparam logic [31:0] WORD_ALL   = 32'hFFFF_FFFF;

   typedef enum logic {
      CMD_ADD    = 1'b0,
      CMD_COMMIT = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_HASH,
      ST_EMIT
   } state_type;

   // start request to the serial crc unit
   typedef struct packed {
      logic             start;
      logic [MAC_W-1:0] mac;
   } crc_req_type;

   // crc result, done pulses for one cycle
   typedef struct packed {
      logic              busy;
      logic              done;
      logic [WSEL_W-1:0] wsel;
      logic [BSEL_W-1:0] bsel;
   } crc_rsp_type;

   // table update control
   typedef struct packed {
      logic              set_en;
      logic [WSEL_W-1:0] wsel;
      logic [BSEL_W-1:0] bsel;
      logic              clear;
   } tbl_ctl_type;

endpackage

`default_nettype wire

// ===== hw/rtl/mhtb_channels.sv =====
// valid/ready channel interfaces for the request and response sides
// depends on mhtb_pkg
`default_nettype none

interface mhtb_req_if;
   logic                     valid;
   logic                     ready;
   logic                     cmd;
   logic [mhtb_pkg::MAC_W-1:0] mac_addr;

   modport source (output valid, output cmd, output mac_addr, input ready);
   modport sink   (input valid, input cmd, input mac_addr, output ready);
endinterface

interface mhtb_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [mhtb_pkg::WSEL_W-1:0] word_index;
   logic [31:0]                 word_value;
   logic                        pass_all;
   logic                        last;

   modport source (output valid, output word_index, output word_value,
                   output pass_all, output last, input ready);
   modport sink   (input valid, input word_index, input word_value,
                   input pass_all, input last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/mhtb_crc_unit.sv =====
// bit-serial big-endian crc-32 over a 48-bit address, one bit per cycle
// depends on mhtb_pkg
`default_nettype none

module mhtb_crc_unit (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire mhtb_pkg::crc_req_type crc_req,
   output mhtb_pkg::crc_rsp_type      crc_rsp
);
   import mhtb_pkg::*;

   logic [31:0]          crc_ff,  crc_in;
   logic [MAC_W-1:0]     sreg_ff, sreg_in;
   logic [BIT_CNT_W-1:0] cnt_ff,  cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic                 fb;

   assign fb = crc_ff[31] ^ sreg_ff[0];

   always_comb begin
      crc_in  = crc_ff;
      sreg_in = sreg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (crc_req.start) begin
         crc_in  = CRC_PRESET;
         sreg_in = crc_req.mac;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         crc_in  = {crc_ff[30:0], 1'b0} ^ (fb ? CRC_POLY : 32'h0);
         sreg_in = {1'b0, sreg_ff[MAC_W-1:1]};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == BIT_CNT_W'(MAC_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      crc_ff  <= crc_in;
      sreg_ff <= sreg_in;
   end

   assign crc_rsp.busy = busy_ff;
   assign crc_rsp.done = done_ff;
   assign crc_rsp.wsel = crc_ff[31:29];
   assign crc_rsp.bsel = crc_ff[28:24];

endmodule

`default_nettype wire

// ===== hw/rtl/mhtb_table.sv =====
// eight 32-bit hash words and the saturating address count
// depends on mhtb_pkg
`default_nettype none

module mhtb_table (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire mhtb_pkg::tbl_ctl_type tbl_ctl,
   input  wire logic [mhtb_pkg::WSEL_W-1:0] rd_index,
   output logic [31:0]                rd_word,
   output logic                       over
);
   import mhtb_pkg::*;

   logic [31:0]        words_ff [WORD_COUNT];
   logic [31:0]        words_in [WORD_COUNT];
   logic [COUNT_W-1:0] count_ff, count_in;

   always_comb begin
      for (int k = 0; k < WORD_COUNT; k++) begin
         words_in[k] = words_ff[k];
         if (tbl_ctl.clear) begin
            words_in[k] = '0;
         end else if (tbl_ctl.set_en && (tbl_ctl.wsel == WSEL_W'(k))) begin
            words_in[k] = words_ff[k] | (32'h1 << tbl_ctl.bsel);
         end
      end
      count_in = count_ff;
      if (tbl_ctl.clear) begin
         count_in = '0;
      end else if (tbl_ctl.set_en && (count_ff <= COUNT_W'(HASH_LIMIT))) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < WORD_COUNT; k++) begin
            words_ff[k] <= '0;
         end
         count_ff <= '0;
      end else begin
         for (int k = 0; k < WORD_COUNT; k++) begin
            words_ff[k] <= words_in[k];
         end
         count_ff <= count_in;
      end
   end

   assign rd_word = words_ff[rd_index];
   assign over    = count_ff > COUNT_W'(HASH_LIMIT);

endmodule

`default_nettype wire

// ===== hw/rtl/multicast_hash_table_builder.sv =====
// add: ready again once the 48 serial crc steps and the table write are done,
// so a new add is only taken after the previous one is through
// commit: 8 response transfers, one per cycle when rsp ready stays high, then idle
// one item at a time; the serial crc shift register sets the add time
// synchronous active-high reset clears the table, the count and the sequencer
// depends on mhtb_pkg, mhtb_channels, mhtb_crc_unit, mhtb_table
`default_nettype none

module multicast_hash_table_builder (
   input  wire logic       clock,
   input  wire logic       reset,
   mhtb_req_if.sink        req_chan,
   mhtb_rsp_if.source      rsp_chan
);
   import mhtb_pkg::*;

   state_type         state_ff, state_in;
   logic [WSEL_W-1:0] idx_ff, idx_in;

   crc_req_type crc_req;
   crc_rsp_type crc_rsp;
   tbl_ctl_type tbl_ctl;
   logic [31:0] rd_word;
   logic        over;
   logic        req_xfer;
   logic        rsp_xfer;
   logic        last_word;

   assign req_xfer  = req_chan.valid && req_chan.ready;
   assign rsp_xfer  = rsp_chan.valid && rsp_chan.ready;
   assign last_word = idx_ff == WSEL_W'(WORD_COUNT - 1);

   // serial crc engine, shared by every add
   mhtb_crc_unit u_crc (
      .clock   (clock),
      .reset   (reset),
      .crc_req (crc_req),
      .crc_rsp (crc_rsp)
   );

   // hash words and address count
   mhtb_table u_table (
      .clock    (clock),
      .reset    (reset),
      .tbl_ctl  (tbl_ctl),
      .rd_index (idx_ff),
      .rd_word  (rd_word),
      .over     (over)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               idx_in = '0;
               if (cmd_type'(req_chan.cmd) == CMD_COMMIT) begin
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_HASH;
               end
            end
         end
         ST_HASH: begin
            if (crc_rsp.done) begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (rsp_xfer) begin
               idx_in = idx_ff + 1'b1;
               if (last_word) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs and unit control
   always_comb begin
      req_chan.ready = 1'b0;
      rsp_chan.valid = 1'b0;
      crc_req.start  = 1'b0;
      crc_req.mac    = req_chan.mac_addr;
      tbl_ctl.set_en = 1'b0;
      tbl_ctl.wsel   = crc_rsp.wsel;
      tbl_ctl.bsel   = crc_rsp.bsel;
      tbl_ctl.clear  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            crc_req.start  = req_chan.valid
                             && (cmd_type'(req_chan.cmd) == CMD_ADD);
         end
         ST_HASH: begin
            // set the selected bit once the last crc step is in
            tbl_ctl.set_en = crc_rsp.done;
         end
         ST_EMIT: begin
            rsp_chan.valid = 1'b1;
            // table and count start over after the final word transfer
            tbl_ctl.clear  = rsp_xfer && last_word;
         end
         default: begin
         end
      endcase
   end

   // response payload straight from the word registers
   assign rsp_chan.word_index = idx_ff;
   assign rsp_chan.word_value = over ? WORD_ALL : rd_word;
   assign rsp_chan.pass_all   = over;
   assign rsp_chan.last       = last_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   // no new request is taken while words are pending
   a_no_req_in_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !req_chan.ready)
      else $error("request taken while emitting");

   // an add transfer always starts the crc engine
   a_add_starts_crc: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && (cmd_type'(req_chan.cmd) == CMD_ADD)) |=> crc_rsp.busy)
      else $error("add did not start crc");

   // a finished crc only arrives while hashing
   a_done_in_hash: assert property (@(posedge clock) disable iff (reset)
      crc_rsp.done |-> (state_ff == ST_HASH))
      else $error("crc done outside hash state");

   // pass-all words are all ones
   a_over_all_ones: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.pass_all) |-> (rsp_chan.word_value == WORD_ALL))
      else $error("pass-all word not all ones");

   // the last word transfer returns to idle with the table cleared
   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && rsp_chan.last) |=> ((state_ff == ST_IDLE) && !over))
      else $error("commit did not finish cleanly");

endmodule

`default_nettype wire
